### rtl/vm_pkg.sv
// shared constants, types and helpers of the vector math unit
`default_nettype none
package vm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int NL        = 3;
  localparam int FW        = 4;
  localparam int OPW       = DW + 1;
  localparam int PROD_W    = 2 * OPW;
  localparam int SAT_W     = PROD_W - FRAC_BITS;
  localparam int SQ_W      = 2 * DW;
  localparam int RT_W      = DW;
  localparam int REM_W     = RT_W + 3;
  localparam int NUM_W     = DW + FRAC_BITS;
  localparam int LAT       = 3 + RT_W + NUM_W;

  localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [FW-1:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_MUL   = 4'd2,
    FN_DIV   = 4'd3,
    FN_ADD_S = 4'd4,
    FN_SUB_S = 4'd5,
    FN_SCALE = 4'd6,
    FN_DIV_S = 4'd7,
    FN_NEG   = 4'd8,
    FN_DOT   = 4'd9,
    FN_MAG   = 4'd10,
    FN_NORM  = 4'd11,
    FN_DIST  = 4'd12
  } vm_func_e;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ov;
  } vm_sat_t;

  // state that rides alongside the square root pipeline
  typedef struct packed {
    vm_func_e             func;
    logic [NL-1:0][DW-1:0] res;
    logic [NL-1:0]         ov;
    logic [DW-1:0]         dot;
    logic                  dot_ov;
    logic                  far;
    logic [NL-1:0][DW-1:0] a;
    logic [NL-1:0][DW-1:0] b;
  } vm_side_t;

  // state that rides alongside the divider pipeline
  typedef struct packed {
    logic [NL-1:0][DW-1:0] res;
    logic [NL-1:0]         ov;
    logic [NL-1:0]         use_q;
    logic [NL-1:0]         neg;
    logic                  dz;
    logic [DW-1:0]         scl;
    logic                  scl_ov;
  } vm_fin_t;

  function automatic vm_sat_t vm_sat(input logic signed [SAT_W-1:0] v);
    vm_sat_t r;
    r.ov  = !((&v[SAT_W-1:DW-1]) || !(|v[SAT_W-1:DW-1]));
    r.val = r.ov ? (v[SAT_W-1] ? Q_MIN : Q_MAX) : v[DW-1:0];
    return r;
  endfunction

  function automatic logic [DW-1:0] vm_abs(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

endpackage
`default_nettype wire

### rtl/vm_lane.sv
// one component lane: add, subtract, negate and the rounded product or square
`default_nettype none
module vm_lane import vm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire vm_func_e                func_i,
  input  wire logic        [DW-1:0]    a_i,
  input  wire logic        [DW-1:0]    b_i,
  output logic             [DW-1:0]    res_o,
  output logic                         ov_o,
  output logic signed      [SAT_W-1:0] rnd_o,
  output logic             [SQ_W-1:0]  sq_o,
  output logic                         far_o,
  output logic             [DW-1:0]    a_o,
  output logic             [DW-1:0]    b_o
);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [OPW-1:0]    ae, be, sum, dif, ng, ex, opx, opy;
  logic                     keep, far;
  vm_sat_t                  sat1, satm;
  logic signed [PROD_W-1:0] prod_q, rnd_full;
  logic        [DW-1:0]     res1_q, a1_q, b1_q;
  logic                     ov1_q, mul1_q, far1_q;

  always_comb begin
    ae   = OPW'($signed(a_i));
    be   = OPW'($signed(b_i));
    sum  = ae + be;
    dif  = ae - be;
    ng   = -ae;
    keep = 1'b1;
    ex   = '0;
    opx  = ae;
    opy  = be;
    unique case (func_i)
      FN_ADD, FN_ADD_S: ex = sum;
      FN_SUB, FN_SUB_S: ex = dif;
      FN_NEG:           ex = ng;
      default:          keep = 1'b0;
    endcase
    if (func_i == FN_MAG || func_i == FN_NORM) begin
      opy = ae;
    end else if (func_i == FN_DIST) begin
      opx = dif;
      opy = dif;
    end
    sat1 = vm_sat(SAT_W'(ex));
    // difference of magnitude 2^31 or more
    far  = dif[OPW-1] ? !(dif[DW-1] && |dif[DW-2:0]) : dif[DW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= opx * opy;
      res1_q <= keep ? sat1.val : '0;
      ov1_q  <= keep && sat1.ov;
      mul1_q <= (func_i == FN_MUL) || (func_i == FN_SCALE);
      far1_q <= far;
      a1_q   <= a_i;
      b1_q   <= b_i;
    end
  end

  always_comb begin
    rnd_full = (prod_q + HALF) >>> FRAC_BITS;
    satm     = vm_sat(rnd_full[SAT_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= mul1_q ? satm.val : res1_q;
      ov_o  <= mul1_q ? satm.ov : ov1_q;
      rnd_o <= rnd_full[SAT_W-1:0];
      sq_o  <= prod_q[SQ_W-1:0];
      far_o <= far1_q;
      a_o   <= a1_q;
      b_o   <= b1_q;
    end
  end

endmodule
`default_nettype wire

### rtl/vm_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module vm_sqrt import vm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [SQ_W-1:0] rad_i,
  output logic      [RT_W-1:0] root_o
);

  logic [REM_W-1:0] rem_q  [RT_W-1];
  logic [SQ_W-1:0]  rad_q  [RT_W-1];
  logic [RT_W-1:0]  root_q [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_st
    logic [REM_W-1:0] rin, r2, trial, rsub;
    logic [RT_W-1:0]  qin;
    logic [SQ_W-1:0]  din;
    logic             ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign din = rad_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign din = rad_q[k-1];
    end

    assign r2    = {rin[REM_W-3:0], din[SQ_W-1 -: 2]};
    assign trial = REM_W'({qin, 2'b01});
    assign ge    = r2 >= trial;
    assign rsub  = r2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {qin[RT_W-2:0], ge};
      end
    end

    if (k < RT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? rsub : r2;
          rad_q[k] <= {din[SQ_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule
`default_nettype wire

### rtl/vm_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vm_div import vm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DW-1:0]    dvs_i,
  output logic      [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DW-1:0]    rem_q [NUM_W-1];
  logic [DW-1:0]    dvs_q [NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_st
    logic [DW-1:0]    rin, din;
    logic [NUM_W-1:0] nin;
    logic [DW:0]      t, tsub;
    logic             ge;

    if (k == 0) begin : g_first
      assign rin = '0;
      assign nin = num_i;
      assign din = dvs_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign nin = nq_q[k-1];
      assign din = dvs_q[k-1];
    end

    // dividend bits shift out at the top while quotient bits shift in
    assign t    = {rin, nin[NUM_W-1]};
    assign ge   = t >= {1'b0, din};
    assign tsub = t - {1'b0, din};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k] <= {nin[NUM_W-2:0], ge};
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? tsub[DW-1:0] : t[DW-1:0];
          dvs_q[k] <= din;
        end
      end
    end
  end

  assign quo_o = nq_q[NUM_W-1];

endmodule
`default_nettype wire

### rtl/vec3_math_unit_core.sv
// Three-component vector ALU in signed Q16.16 fixed point. One transfer on the
// input stream carries an operation code in tuser and two vectors in tdata; one
// transfer on the output stream returns the result vector, the scalar result and
// the overflow and divide-by-zero flags. The unit is fully pipelined: it takes a
// new item every cycle unless the output stalls, and each item passes through two
// lane stages, one merge stage, a 32-stage square root, a 48-stage divider and the
// output register; every operation goes through the same stages, so results leave
// in input order. Backpressure on the output stalls the whole pipe.
`default_nettype none
module vec3_math_unit_core import vm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire logic [191:0]   s_axis_tdata_i,  // a_x, a_y, a_z, b_x, b_y, b_z
  input  wire logic [FW-1:0]  s_axis_tuser_i,  // func
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic      [127:0]   m_axis_tdata_o,  // r_x, r_y, r_z, r_scalar
  output logic      [1:0]     m_axis_tuser_o   // overflow, div_zero
);

  logic                    en;
  logic [LAT-1:0]          vld_q;
  logic                    out_vld_q;
  vm_func_e                func_in;
  vm_func_e                func1_q, func2_q;
  logic                    scalar_op;

  logic [NL-1:0][DW-1:0]   a_in, b_in;
  logic [NL-1:0][DW-1:0]   l_res, l_a, l_b;
  logic [NL-1:0]           l_ov, l_far;
  logic signed [SAT_W-1:0] l_rnd [NL];
  logic [SQ_W-1:0]         l_sq  [NL];

  logic [SQ_W-1:0]         ssq_q;
  vm_side_t                side_m_q;
  vm_side_t                side_dl_q [RT_W];
  vm_side_t                sd;
  logic signed [SAT_W-1:0] dot_sum;
  vm_sat_t                 dot_sat;

  logic [RT_W-1:0]         root;
  vm_fin_t                 fin;
  vm_fin_t                 fin_dl_q [NUM_W];
  vm_fin_t                 fd;
  logic [NL-1:0][DW-1:0]   amag, bmag, dvs;
  logic [NUM_W-1:0]        quo [NL];

  logic [NL-1:0][DW-1:0]   r_vec;
  logic [NL-1:0]           q_ov;
  logic [DW-1:0]           out_x_q, out_y_q, out_z_q, out_s_q;
  logic                    out_ov_q, out_dz_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign func_in         = vm_func_e'(s_axis_tuser_i);
  assign scalar_op       = (func_in == FN_ADD_S) || (func_in == FN_SUB_S) ||
                           (func_in == FN_SCALE) || (func_in == FN_DIV_S);

  for (genvar i = 0; i < NL; i++) begin : g_lane
    assign a_in[i] = s_axis_tdata_i[i*DW +: DW];
    assign b_in[i] = scalar_op ? s_axis_tdata_i[NL*DW +: DW]
                               : s_axis_tdata_i[(NL+i)*DW +: DW];

    vm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .func_i (func_in),
      .a_i    (a_in[i]),
      .b_i    (b_in[i]),
      .res_o  (l_res[i]),
      .ov_o   (l_ov[i]),
      .rnd_o  (l_rnd[i]),
      .sq_o   (l_sq[i]),
      .far_o  (l_far[i]),
      .a_o    (l_a[i]),
      .b_o    (l_b[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[LAT-1];
    end
  end

  // merge stage: dot product sum and sum of squares
  always_comb begin
    dot_sum = l_rnd[0] + l_rnd[1] + l_rnd[2];
    dot_sat = vm_sat(dot_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q         <= func_in;
      func2_q         <= func1_q;
      ssq_q           <= l_sq[0] + l_sq[1] + l_sq[2];
      side_m_q.func   <= func2_q;
      side_m_q.res    <= l_res;
      side_m_q.ov     <= l_ov;
      side_m_q.dot    <= dot_sat.val;
      side_m_q.dot_ov <= dot_sat.ov;
      side_m_q.far    <= |l_far;
      side_m_q.a      <= l_a;
      side_m_q.b      <= l_b;
      side_dl_q[0]    <= side_m_q;
      for (int k = 1; k < RT_W; k++) begin
        side_dl_q[k] <= side_dl_q[k-1];
      end
    end
  end

  vm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ssq_q),
    .root_o (root)
  );

  // divider setup and scalar results
  assign sd = side_dl_q[RT_W-1];

  always_comb begin
    fin.res    = sd.res;
    fin.ov     = sd.ov;
    fin.use_q  = '0;
    fin.neg    = '0;
    fin.dz     = 1'b0;
    fin.scl    = '0;
    fin.scl_ov = 1'b0;
    for (int i = 0; i < NL; i++) begin
      amag[i] = vm_abs(sd.a[i]);
      bmag[i] = vm_abs(sd.b[i]);
      dvs[i]  = bmag[i];
      if (sd.func == FN_DIV || sd.func == FN_DIV_S) begin
        fin.neg[i] = sd.a[i][DW-1] ^ sd.b[i][DW-1];
        if (sd.b[i] == '0) begin
          fin.dz     = 1'b1;
          fin.res[i] = sd.a[i][DW-1] ? Q_MIN : ((|sd.a[i]) ? Q_MAX : '0);
        end else begin
          fin.use_q[i] = 1'b1;
        end
      end else if (sd.func == FN_NORM) begin
        dvs[i]     = root;
        fin.neg[i] = sd.a[i][DW-1];
        fin.res[i] = '0;
        if (root == '0) begin
          fin.dz = 1'b1;
        end else begin
          fin.use_q[i] = 1'b1;
        end
      end
    end
    unique case (sd.func)
      FN_DOT: begin
        fin.scl    = sd.dot;
        fin.scl_ov = sd.dot_ov;
      end
      FN_MAG: begin
        fin.scl    = root[RT_W-1] ? Q_MAX : root;
        fin.scl_ov = root[RT_W-1];
      end
      FN_DIST: begin
        fin.scl    = (sd.far || root[RT_W-1]) ? Q_MAX : root;
        fin.scl_ov = sd.far || root[RT_W-1];
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < NL; i++) begin : g_div
    vm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({amag[i], {FRAC_BITS{1'b0}}}),
      .dvs_i (dvs[i]),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_dl_q[0] <= fin;
      for (int k = 1; k < NUM_W; k++) begin
        fin_dl_q[k] <= fin_dl_q[k-1];
      end
    end
  end

  // quotient sign and saturation, then output register
  assign fd = fin_dl_q[NUM_W-1];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      r_vec[i] = fd.res[i];
      q_ov[i]  = 1'b0;
      if (fd.use_q[i]) begin
        if (fd.neg[i]) begin
          q_ov[i]  = (|quo[i][NUM_W-1:DW]) || (quo[i][DW-1] && |quo[i][DW-2:0]);
          r_vec[i] = q_ov[i] ? Q_MIN : (~quo[i][DW-1:0] + DW'(1));
        end else begin
          q_ov[i]  = |quo[i][NUM_W-1:DW-1];
          r_vec[i] = q_ov[i] ? Q_MAX : quo[i][DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q  <= r_vec[0];
      out_y_q  <= r_vec[1];
      out_z_q  <= r_vec[2];
      out_s_q  <= fd.scl;
      out_ov_q <= (|fd.ov) || (|q_ov) || fd.scl_ov;
      out_dz_q <= fd.dz;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_s_q, out_z_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = {out_dz_q, out_ov_q};

endmodule
`default_nettype wire

### bench/tb_vec3_math_unit_core.sv
// testbench for the vector math unit: random and directed operations checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_vec3_math_unit_core;
  import vm_pkg::*;

  typedef struct {
    logic [3:0]  func;
    logic [31:0] a [3];
    logic [31:0] b [3];
  } vec_op_t;

  typedef struct {
    logic [127:0] data;
    logic [1:0]   flags;
  } vec_res_t;

  localparam int PIPE_LAT = 84;
  localparam int FB       = 16;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic [3:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  vec_op_t  pending_ops[$];
  vec_res_t expected_results[$];
  int       mismatch_count = 0;
  bit       hold_sink = 1'b0;
  bit       drain_req = 1'b0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       src_gap_max = 11;
  int       sink_gap_max = 11;

  vec3_math_unit_core dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint q_sat(input longint v, inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint q_mul(input longint x, input longint y);
    return (x * y + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint q_div_mag(input longint x, input longint unsigned d,
                                       input bit neg_d, inout bit ov);
    longint unsigned mx;
    longint unsigned q;
    mx = (x < 0) ? longint'(-x) : x;
    q  = (mx << FB) / d;
    if ((x < 0) != neg_d) begin
      if (q > 64'd2147483648) begin
        ov = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic longint q_div(input longint x, input longint y, inout bit ov,
                                   inout bit dz);
    if (y == 0) begin
      dz = 1'b1;
      return (x > 0) ? 64'sd2147483647 : ((x < 0) ? -64'sd2147483648 : 0);
    end
    return q_div_mag(x, (y < 0) ? longint'(-y) : y, y < 0, ov);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec_res_t predict_vec_op(input vec_op_t op);
    longint a [3];
    longint b [3];
    longint r [3];
    longint d [3];
    longint s;
    longint unsigned sq;
    longint unsigned m;
    bit ov;
    bit dz;
    bit far;
    vec_res_t res;
    s = 0;
    ov = 0;
    dz = 0;
    far = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(op.a[i]));
      b[i] = longint'($signed(op.b[i]));
      r[i] = 0;
    end
    case (op.func)
      FN_ADD:   for (int i = 0; i < 3; i++) r[i] = q_sat(a[i] + b[i], ov);
      FN_SUB:   for (int i = 0; i < 3; i++) r[i] = q_sat(a[i] - b[i], ov);
      FN_MUL:   for (int i = 0; i < 3; i++) r[i] = q_sat(q_mul(a[i], b[i]), ov);
      FN_DIV:   for (int i = 0; i < 3; i++) r[i] = q_div(a[i], b[i], ov, dz);
      FN_ADD_S: for (int i = 0; i < 3; i++) r[i] = q_sat(a[i] + b[0], ov);
      FN_SUB_S: for (int i = 0; i < 3; i++) r[i] = q_sat(a[i] - b[0], ov);
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = q_sat(q_mul(a[i], b[0]), ov);
      FN_DIV_S: for (int i = 0; i < 3; i++) r[i] = q_div(a[i], b[0], ov, dz);
      FN_NEG:   for (int i = 0; i < 3; i++) r[i] = q_sat(-a[i], ov);
      FN_DOT: s = q_sat(q_mul(a[0], b[0]) + q_mul(a[1], b[1]) + q_mul(a[2], b[2]), ov);
      FN_MAG: begin
        for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
        s = q_sat(longint'(root_floor(sq)), ov);
      end
      FN_NORM: begin
        for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
        m = root_floor(sq);
        if (m == 0) dz = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = q_div_mag(a[i], m, 1'b0, ov);
      end
      FN_DIST: begin
        for (int i = 0; i < 3; i++) begin
          d[i] = a[i] - b[i];
          if (d[i] >= 64'sd2147483648 || d[i] <= -64'sd2147483648) far = 1'b1;
          sq += longint'(d[i] * d[i]);
        end
        if (far) begin
          ov = 1'b1;
          s = 64'sd2147483647;
        end else begin
          s = q_sat(longint'(root_floor(sq)), ov);
        end
      end
      default: ;
    endcase
    res.data  = {s[31:0], r[2][31:0], r[1][31:0], r[0][31:0]};
    res.flags = {dz, ov};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  function automatic logic [31:0] rand_comp(input int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      4: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic [3:0] f, input logic [31:0] ax, input logic [31:0] ay,
                         input logic [31:0] az, input logic [31:0] bx,
                         input logic [31:0] by, input logic [31:0] bz);
    vec_op_t op;
    op.func = f;
    op.a[0] = ax;
    op.a[1] = ay;
    op.a[2] = az;
    op.b[0] = bx;
    op.b[1] = by;
    op.b[2] = bz;
    pending_ops.push_back(op);
  endtask

  // source side
  always @(posedge clk_i) begin
    int gap;
    gap = src_gap;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_results.push_back(predict_vec_op(pending_ops.pop_front()));
      gap = $urandom_range(0, src_gap_max);
    end else if (gap > 0 && !s_axis_tvalid_i) begin
      gap = gap - 1;
    end
    src_gap <= gap;
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (pending_ops.size() > 0 && !drain_req && rst_ni && gap == 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= pending_ops[0].func;
        s_axis_tdata_i  <= {pending_ops[0].b[2], pending_ops[0].b[1], pending_ops[0].b[0],
                            pending_ops[0].a[2], pending_ops[0].a[1], pending_ops[0].a[0]};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // sink side
  always @(posedge clk_i) begin
    vec_res_t want;
    int gap;
    gap = sink_gap;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata_o, '0);
      end else begin
        want = expected_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_axis_tdata_o[32*i +: 32] !== want.data[32*i +: 32])
            report_mismatch($sformatf("field %0d", i), 128'(m_axis_tdata_o[32*i +: 32]),
                            128'(want.data[32*i +: 32]));
        if (m_axis_tuser_o[0] !== want.flags[0])
          report_mismatch("overflow", 128'(m_axis_tuser_o[0]), 128'(want.flags[0]));
        if (m_axis_tuser_o[1] !== want.flags[1])
          report_mismatch("div_zero", 128'(m_axis_tuser_o[1]), 128'(want.flags[1]));
      end
      gap = $urandom_range(0, sink_gap_max);
    end else if (gap > 0) begin
      gap = gap - 1;
    end
    sink_gap <= gap;
    m_axis_tready_i <= rst_ni && !hold_sink && (gap == 0);
  end

  initial begin
    int k;
    int f;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: each operation, extremes, zero divisors, zero vector, far distance
    for (f = 0; f < 16; f++)
      push_op(f[3:0], 32'h7fffffff, 32'h80000000, 32'h00018000,
              32'h7fffffff, 32'h7fffffff, 32'hfffe0000);
    push_op(FN_DIV, 32'h00010000, 32'hffff0000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_op(FN_DIV_S, 32'h00030000, 32'h80000000, 32'h0, 32'h0, 32'h5, 32'h5);
    push_op(FN_NORM, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1);
    push_op(FN_NORM, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0, 32'h0, 32'h0);
    push_op(FN_DIST, 32'h7fffffff, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0);
    push_op(FN_DIST, 32'h00010000, 32'h00020000, 32'h00020000, 32'h0, 32'h0, 32'h0);
    push_op(FN_MAG, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0);
    push_op(FN_MUL, 32'h00008000, 32'hffff8000, 32'h1, 32'h00000001, 32'h00010000, 32'h1);
    push_op(FN_NEG, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    for (k = 0; k < 800; k++) begin
      if (k == 300) begin
        // hold the sink while the source keeps offering, so the pipe backs up
        wait (pending_ops.size() == 0);
        hold_sink = 1'b1;
        for (int j = 0; j < 200; j++) push_op(4'($urandom_range(0, 15)),
          rand_comp($urandom_range(0, 7)),
          rand_comp($urandom_range(0, 7)), rand_comp($urandom_range(0, 7)),
          rand_comp($urandom_range(0, 7)), rand_comp($urandom_range(0, 7)),
          rand_comp($urandom_range(0, 7)));
        src_gap_max = 0;
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
        wait (pending_ops.size() == 0);
        // source pauses until everything has drained
        drain_req = 1'b1;
        wait (expected_results.size() == 0);
        drain_req = 1'b0;
        src_gap_max = 11;
      end
      if (k == 500) sink_gap_max = 0;
      if (k == 650) sink_gap_max = 11;
      f = $urandom_range(0, 15);
      push_op(f[3:0], rand_comp($urandom_range(0, 7)), rand_comp($urandom_range(0, 7)),
              rand_comp($urandom_range(0, 7)), rand_comp($urandom_range(0, 7)),
              rand_comp($urandom_range(0, 7)), rand_comp($urandom_range(0, 7)));
      if (pending_ops.size() > 50) wait (pending_ops.size() < 20);
    end
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** vec3_math_unit_core: PASSED **");
    end else begin
      $display("** vec3_math_unit_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("** vec3_math_unit_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
